// ----- rtl/cfrq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cfrq_pkg;

   localparam int BEATS_PER_FRAME = 8;
   localparam int BEAT_W          = 3;
   localparam int ID_W            = 29;
   localparam int CODE_W          = 4;
   localparam int WORD_W          = 64;
   localparam int COUNT_W         = 32;
   localparam int BYTES_W         = 7;
   localparam int FILL_W          = 4;
   localparam int SEQ_W           = 8;
   localparam int HDR_W           = 34;

   localparam logic [ID_W-1:0]   TRACKED_RESET = 29'h111;
   localparam logic [BEAT_W-1:0] FIRST_BEAT    = 3'd0;
   localparam logic [BEAT_W-1:0] LAST_BEAT     = 3'd7;
   localparam logic [CODE_W-1:0] CODE_64_BYTES = 4'd15;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_PUSH_OK   = 2'd0,
      KIND_PUSH_DROP = 2'd1,
      KIND_POP_DATA  = 2'd2,
      KIND_POP_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_POP_FETCH = 2'd1,
      ST_POP_SEND  = 2'd2
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [BEAT_W-1:0]   beat_index;
      logic [ID_W-1:0]     frame_identifier;
      logic                extended_flag;
      logic [CODE_W-1:0]   length_code;
      logic [WORD_W-1:0]   payload_word;
   } req_item_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [WORD_W-1:0]   payload_beat;
      logic [ID_W-1:0]     head_identifier;
      logic                head_extended;
      logic [CODE_W-1:0]   head_length_code;
      logic                last_of_run;
      logic [COUNT_W-1:0]  frames_seen;
      logic [COUNT_W-1:0]  frames_dropped;
      logic [COUNT_W-1:0]  sequence_gaps;
      logic [BYTES_W-1:0]  last_byte_count;
      logic [FILL_W-1:0]   fill_level;
   } rsp_item_type;

   // stored header, code in the top bits
   typedef struct packed {
      logic [CODE_W-1:0]   length_code;
      logic                extended;
      logic [ID_W-1:0]     identifier;
   } header_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  seen;
      logic [COUNT_W-1:0]  dropped;
      logic [COUNT_W-1:0]  gaps;
      logic [BYTES_W-1:0]  last_bytes;
   } stats_type;

   function automatic logic [BYTES_W-1:0] dlc_to_bytes(input logic [CODE_W-1:0] code);
      logic [BYTES_W-1:0] bytes;
      begin
         case (code)
            4'd9:    bytes = 7'd12;
            4'd10:   bytes = 7'd16;
            4'd11:   bytes = 7'd20;
            4'd12:   bytes = 7'd24;
            4'd13:   bytes = 7'd32;
            4'd14:   bytes = 7'd48;
            4'd15:   bytes = 7'd64;
            default: bytes = {3'd0, code};
         endcase
         return bytes;
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cfrq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cfrq_rx_track.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfrq_rx_track
   import cfrq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [ID_W-1:0]   csr_write_data,
   input  wire logic              beat_valid,
   input  wire req_item_type      beat,
   input  wire logic              drop,
   output stats_type              stats_next
);

   logic [ID_W-1:0]  tracked_ff;
   stats_type        stats_ff;
   stats_type        stats_in;
   logic [SEQ_W-1:0] expected_ff;
   logic [SEQ_W-1:0] expected_in;
   logic             started_ff;
   logic             started_in;
   logic             seq_hit;
   logic [SEQ_W-1:0] seq;
   logic [SEQ_W-1:0] gap;

   assign seq = beat.payload_word[SEQ_W-1:0];
   assign gap = seq - expected_ff;
   assign seq_hit = beat_valid && beat.beat_index == FIRST_BEAT
                 && beat.frame_identifier == tracked_ff
                 && beat.length_code == CODE_64_BYTES;

   always_comb begin
      stats_in    = stats_ff;
      expected_in = expected_ff;
      started_in  = started_ff;
      if (seq_hit) begin
         // first tracked frame only primes the expected number
         if (started_ff) begin
            stats_in.gaps = stats_ff.gaps + COUNT_W'(gap);
         end
         expected_in = seq + 1'b1;
         started_in  = 1'b1;
      end
      if (beat_valid && beat.beat_index == LAST_BEAT) begin
         stats_in.seen       = stats_ff.seen + 1'b1;
         stats_in.last_bytes = dlc_to_bytes(beat.length_code);
         if (drop) begin
            stats_in.dropped = stats_ff.dropped + 1'b1;
         end
      end
   end

   assign stats_next = stats_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff  <= TRACKED_RESET;
         stats_ff    <= '0;
         expected_ff <= '0;
         started_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tracked_ff <= csr_write_data;
         end
         stats_ff    <= stats_in;
         expected_ff <= expected_in;
         started_ff  <= started_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/can_frame_receive_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// CAN FD receive queue of QUEUE_DEPTH frame slots, eight 64-bit beats each.
// req channel: one item is a push of one frame beat or a pop of the head frame.
// rsp channel: a push or an empty pop gives one item; a pop of a held frame
//   gives eight data items, the last flagged by last_of_run.
// csr port: a write loads tracked_identifier at once; write only when idle.
// Push: taken in ST_IDLE, result registered the cycle after, so beats
//   stream at one per cycle while the receiver keeps up. Beat 7 commits the
//   slot, or drops the frame when only one free slot is left.
// Pop: ST_IDLE takes the item and starts the memory reads, ST_POP_FETCH
//   waits for the read data, then ST_POP_SEND gives one beat per cycle
//   when not stalled; the payload memory's single read port sets the rate.
// A pop of an empty queue is answered straight from ST_IDLE, like a push.
// Receiver stall: the output register holds its item; a new request is only
//   taken once that register is free or being emptied, and pop beats wait.
// Reset (synchronous): indices, counters and sequence tracking clear and
//   tracked_identifier returns to 0x111; memory contents stay undefined.
module can_frame_receive_queue
   import cfrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_item_type  req_item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type       rsp_item,
   input  wire logic          csr_write_enable,
   input  wire logic [ID_W-1:0] csr_write_data
);

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PAY_D  = QUEUE_DEPTH * BEATS_PER_FRAME;
   localparam int PADR_W = IDX_W + BEAT_W;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              out_free;
   logic              req_accept;
   logic              load_rsp;
   logic              push_beat;
   logic              pop_start;
   logic              beat_step;
   logic              queue_empty;
   logic              last_beat_in;
   logic              full;
   logic              commit;
   logic              drop;
   logic [IDX_W-1:0]  tail_next;
   logic              hdr_rd_en;
   logic              pay_rd_en;
   logic [PADR_W-1:0] pay_rd_addr;
   logic [WORD_W-1:0] pay_rd_data;
   logic [HDR_W-1:0]  hdr_rd_data;
   header_type        hdr_wr;
   header_type        hdr_head;
   stats_type         stats_next;
   logic [FILL_W-1:0] fill_now;
   logic [FILL_W-1:0] fill_push;

   // tail minus head modulo depth, low bits only
   function automatic logic [FILL_W-1:0] fill_of(input logic [IDX_W-1:0] t,
                                                 input logic [IDX_W-1:0] h);
      logic [IDX_W+FILL_W:0] diff;
      begin
         diff = (IDX_W+FILL_W+1)'(t) - (IDX_W+FILL_W+1)'(h);
         if (t < h) begin
            diff = diff + (IDX_W+FILL_W+1)'(QUEUE_DEPTH);
         end
         return diff[FILL_W-1:0];
      end
   endfunction

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_accept  = req_valid && req_ready;
   assign queue_empty = head_ff == tail_ff;
   assign tail_next   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign full        = tail_next == head_ff;
   assign last_beat_in = req_item.beat_index == LAST_BEAT;
   assign commit      = push_beat && last_beat_in && !full;
   assign drop        = push_beat && last_beat_in && full;
   assign fill_now    = fill_of(tail_ff, head_ff);
   assign fill_push   = fill_of(commit ? tail_next : tail_ff, head_ff);
   assign hdr_head    = header_type'(hdr_rd_data);

   assign hdr_wr.length_code = req_item.length_code;
   assign hdr_wr.extended    = req_item.extended_flag;
   assign hdr_wr.identifier  = req_item.frame_identifier;

   // payload beats: address is slot then beat; the tail slot is always free
   cfrq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PAY_D)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (push_beat),
      .wr_addr ({tail_ff, req_item.beat_index}),
      .wr_data (req_item.payload_word),
      .rd_en   (pay_rd_en),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   // headers, written on commit only
   cfrq_ram #(
      .WIDTH (HDR_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_header_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (tail_ff),
      .wr_data (HDR_W'(hdr_wr)),
      .rd_en   (hdr_rd_en),
      .rd_addr (head_ff),
      .rd_data (hdr_rd_data)
   );

   cfrq_rx_track u_rx_track (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .beat_valid       (push_beat),
      .beat             (req_item),
      .drop             (drop),
      .stats_next       (stats_next)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_start) begin
               state_in = ST_POP_FETCH;
            end
         end
         ST_POP_FETCH: begin
            state_in = ST_POP_SEND;
         end
         ST_POP_SEND: begin
            if (out_free && beat_ff == LAST_BEAT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      push_beat   = 1'b0;
      pop_start   = 1'b0;
      beat_step   = 1'b0;
      hdr_rd_en   = 1'b0;
      pay_rd_en   = 1'b0;
      pay_rd_addr = {head_ff, FIRST_BEAT};
      rsp_item_in = '0;
      rsp_item_in.frames_seen     = stats_next.seen;
      rsp_item_in.frames_dropped  = stats_next.dropped;
      rsp_item_in.sequence_gaps   = stats_next.gaps;
      rsp_item_in.last_byte_count = stats_next.last_bytes;
      rsp_item_in.fill_level      = fill_now;
      rsp_item_in.last_of_run     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_accept) begin
               if (req_item.operation == OP_PUSH) begin
                  push_beat = 1'b1;
                  load_rsp  = 1'b1;
                  rsp_item_in.result_kind = drop ? KIND_PUSH_DROP : KIND_PUSH_OK;
                  rsp_item_in.fill_level  = fill_push;
               end else if (queue_empty) begin
                  load_rsp = 1'b1;
                  rsp_item_in.result_kind = KIND_POP_EMPTY;
               end else begin
                  pop_start = 1'b1;
                  hdr_rd_en = 1'b1;
                  pay_rd_en = 1'b1;
               end
            end
         end
         ST_POP_FETCH: begin
         end
         ST_POP_SEND: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_item_in.result_kind      = KIND_POP_DATA;
               rsp_item_in.payload_beat     = pay_rd_data;
               rsp_item_in.head_identifier  = hdr_head.identifier;
               rsp_item_in.head_extended    = hdr_head.extended;
               rsp_item_in.head_length_code = hdr_head.length_code;
               rsp_item_in.last_of_run      = beat_ff == LAST_BEAT;
               if (beat_ff != LAST_BEAT) begin
                  // fetch the following beat while this one goes out
                  beat_step   = 1'b1;
                  pay_rd_en   = 1'b1;
                  pay_rd_addr = {slot_ff, beat_ff + 1'b1};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      slot_in = slot_ff;
      beat_in = beat_ff;
      if (pop_start) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         slot_in = head_ff;
         beat_in = FIRST_BEAT;
      end else if (beat_step) begin
         beat_in = beat_ff + 1'b1;
      end
      if (commit) begin
         tail_in = tail_next;
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (load_rsp) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// ----- rtl/cfrq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfrq_checker
   import cfrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_item
);

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH - 1);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind == KIND_POP_EMPTY
      |-> rsp_item.fill_level == '0 && rsp_item.last_of_run)
      else $error("empty pop with queue not empty");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind == KIND_PUSH_DROP
      |-> rsp_item.fill_level == FULL_FILL)
      else $error("frame dropped with free slots");

   a_push_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.result_kind == KIND_PUSH_OK
                    || rsp_item.result_kind == KIND_PUSH_DROP)
      |-> rsp_item.payload_beat == '0 && rsp_item.head_identifier == '0
          && rsp_item.last_of_run)
      else $error("push item carries pop data");

endmodule

bind can_frame_receive_queue cfrq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_cfrq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ----- sim/tb_can_frame_receive_queue.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the CAN FD frame receive queue.
// A behavioural copy of the queue predicts every rsp item when its req item
// is taken; a checker process pops the oldest prediction for each rsp item.
module tb_can_frame_receive_queue;
   import cfrq_pkg::*;

   localparam int DEPTH           = 16;
   localparam int SLOT_BEATS      = BEATS_PER_FRAME;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int SETTLE_CYCLES   = 12;          // a little over one pop of a frame
   localparam int TIMEOUT_NS      = 5_000_000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_item_type        req_item;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_item_type        rsp_item;
   logic                csr_write_enable;
   logic [ID_W-1:0]     csr_write_data;

   // idling controls, set by the test sequence
   bit                  req_pauses = 1'b0;
   bit                  rsp_pauses = 1'b0;
   int                  hold_offs_asked = 0;

   // statistics
   int                  items_sent = 0;
   int                  results_checked = 0;
   int                  mismatch_count = 0;
   int                  settings_used = 1;

   // ---------------------------------------------------------------------
   // Behavioural copy of the queue
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]     tracked_id;
   logic [WORD_W-1:0]   beat_mem [DEPTH*SLOT_BEATS];
   bit                  beat_written [DEPTH*SLOT_BEATS];
   header_type          header_mem [DEPTH];
   int                  head_slot;
   int                  tail_slot;
   logic [COUNT_W-1:0]  frames_seen_cnt;
   logic [COUNT_W-1:0]  frames_dropped_cnt;
   logic [COUNT_W-1:0]  gap_total;
   logic [SEQ_W-1:0]    next_seq;
   bit                  seq_started;
   logic [BYTES_W-1:0]  last_bytes;
   rsp_item_type        pending_rsp_items [$];

   can_frame_receive_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int queue_fill();
      return (tail_slot - head_slot + DEPTH) % DEPTH;
   endfunction

   // CAN FD length code to payload bytes
   function automatic logic [BYTES_W-1:0] code_to_bytes(input logic [CODE_W-1:0] code);
      if (code <= 4'd8)
         return BYTES_W'(code);
      if (code <= 4'd12)
         return BYTES_W'(12 + 4 * (code - 4'd9));
      return (code == 4'd13) ? 7'd32 : (code == 4'd14) ? 7'd48 : 7'd64;
   endfunction

   // rsp item carrying the counters as they stand now
   function automatic rsp_item_type stamp_counters(input kind_type kind, input logic last);
      rsp_item_type r;
      r = '0;
      r.result_kind     = kind;
      r.last_of_run     = last;
      r.frames_seen     = frames_seen_cnt;
      r.frames_dropped  = frames_dropped_cnt;
      r.sequence_gaps   = gap_total;
      r.last_byte_count = last_bytes;
      r.fill_level      = FILL_W'(queue_fill());
      return r;
   endfunction

   task automatic clear_model();
      tracked_id         = TRACKED_RESET;
      head_slot          = 0;
      tail_slot          = 0;
      frames_seen_cnt    = '0;
      frames_dropped_cnt = '0;
      gap_total          = '0;
      next_seq           = '0;
      seq_started        = 1'b0;
      last_bytes         = '0;
      foreach (beat_written[i]) beat_written[i] = 1'b0;
   endtask

   // Applies one accepted req item to the copy and queues the rsp items it causes.
   task automatic advance_queue_model(input req_item_type it);
      rsp_item_type r;
      kind_type     kind;
      header_type   hdr;
      int           base;
      int           nxt;
      int           k;
      if (it.operation == OP_PUSH) begin
         // the tail slot is always free, so every beat lands there
         base = tail_slot * SLOT_BEATS + int'(it.beat_index);
         beat_mem[base]     = it.payload_word;
         beat_written[base] = 1'b1;
         kind = KIND_PUSH_OK;
         // sequence check: first beat of a 64-byte frame on the tracked id,
         // extended flag ignored
         if (it.beat_index == FIRST_BEAT && it.frame_identifier == tracked_id &&
             it.length_code == CODE_64_BYTES) begin
            if (seq_started)
               gap_total = gap_total +
                           COUNT_W'(SEQ_W'(it.payload_word[SEQ_W-1:0] - next_seq));
            seq_started = 1'b1;
            next_seq    = it.payload_word[SEQ_W-1:0] + 1'b1;
         end
         if (it.beat_index == LAST_BEAT) begin
            nxt = (tail_slot + 1) % DEPTH;
            frames_seen_cnt = frames_seen_cnt + 1'b1;
            last_bytes      = code_to_bytes(it.length_code);
            if (nxt != head_slot) begin
               // header comes from the closing beat
               hdr.identifier  = it.frame_identifier;
               hdr.extended    = it.extended_flag;
               hdr.length_code = it.length_code;
               header_mem[tail_slot] = hdr;
               tail_slot = nxt;
            end else begin
               frames_dropped_cnt = frames_dropped_cnt + 1'b1;
               kind = KIND_PUSH_DROP;
            end
         end
         pending_rsp_items.push_back(stamp_counters(kind, 1'b1));
      end else if (head_slot == tail_slot) begin
         pending_rsp_items.push_back(stamp_counters(KIND_POP_EMPTY, 1'b1));
      end else begin
         base = head_slot * SLOT_BEATS;
         hdr  = header_mem[head_slot];
         head_slot = (head_slot + 1) % DEPTH;
         for (k = 0; k < SLOT_BEATS; k++) begin
            r = stamp_counters(KIND_POP_DATA, k == SLOT_BEATS - 1);
            r.payload_beat     = beat_mem[base + k];
            r.head_identifier  = hdr.identifier;
            r.head_extended    = hdr.extended;
            r.head_length_code = hdr.length_code;
            pending_rsp_items.push_back(r);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("[%0t] rsp item %0d: %s got 0x%0h, expected 0x%0h",
                  $time, results_checked, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic check_rsp_item(input rsp_item_type got);
      rsp_item_type want;
      results_checked++;
      if (pending_rsp_items.size() == 0) begin
         report_mismatch("item with nothing outstanding, kind", got.result_kind, 0);
      end else begin
         want = pending_rsp_items.pop_front();
         compare_field("result_kind",      got.result_kind,      want.result_kind);
         compare_field("payload_beat",     got.payload_beat,     want.payload_beat);
         compare_field("head_identifier",  got.head_identifier,  want.head_identifier);
         compare_field("head_extended",    got.head_extended,    want.head_extended);
         compare_field("head_length_code", got.head_length_code, want.head_length_code);
         compare_field("last_of_run",      got.last_of_run,      want.last_of_run);
         compare_field("frames_seen",      got.frames_seen,      want.frames_seen);
         compare_field("frames_dropped",   got.frames_dropped,   want.frames_dropped);
         compare_field("sequence_gaps",    got.sequence_gaps,    want.sequence_gaps);
         compare_field("last_byte_count",  got.last_byte_count,  want.last_byte_count);
         compare_field("fill_level",       got.fill_level,       want.fill_level);
      end
   endtask

   // sample on the rising edge, before the block's own updates land
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_rsp_item(rsp_item);
   end

   // ---------------------------------------------------------------------
   // Idling
   // ---------------------------------------------------------------------
   // mostly no gap, often a short one, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   initial begin : rsp_ready_driver
      int stall;
      int hold_offs_served;
      rsp_ready = 1'b0;
      stall = 0;
      hold_offs_served = 0;
      forever begin
         @(negedge clock);
         if (hold_offs_served != hold_offs_asked) begin
            hold_offs_served = hold_offs_asked;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall == 0 && rsp_pauses)
            stall = idle_length();
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_item_type push_item(input logic [BEAT_W-1:0] beat,
                                              input logic [ID_W-1:0] id,
                                              input logic ext,
                                              input logic [CODE_W-1:0] code,
                                              input logic [WORD_W-1:0] word);
      req_item_type it;
      it.operation        = OP_PUSH;
      it.beat_index       = beat;
      it.frame_identifier = id;
      it.extended_flag    = ext;
      it.length_code      = code;
      it.payload_word     = word;
      return it;
   endfunction

   // pop with junk in the unused fields
   function automatic req_item_type pop_item();
      req_item_type it;
      it = push_item(BEAT_W'($urandom), ID_W'($urandom), 1'($urandom),
                     CODE_W'($urandom), {$urandom, $urandom});
      it.operation = OP_POP;
      return it;
   endfunction

   // Sends one item; called and returns on a falling edge.
   task automatic send_request(input req_item_type it);
      int gap;
      int beat;
      // never close a frame over beats the slot has not yet held, so that
      // a later pop cannot read a location written since reset by nobody
      if (it.operation == OP_PUSH && it.beat_index == LAST_BEAT)
         for (beat = SLOT_BEATS - 2; beat >= 0; beat--)
            if (!beat_written[tail_slot * SLOT_BEATS + beat])
               it.beat_index = BEAT_W'(beat);
      gap = req_pauses ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      advance_queue_model(it);
      items_sent++;
      @(negedge clock);
   endtask

   // sender stops until every outstanding rsp item is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp_items.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only while idle; the copy takes the value once the edge has passed
   task automatic write_tracked(input logic [ID_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracked_id = value;
      settings_used++;
   endtask

   function automatic logic [ID_W-1:0] pick_identifier();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return tracked_id;
      if (roll < 55)
         return tracked_id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
      if (roll < 62)
         return '0;
      if (roll < 69)
         return '1;
      return ID_W'($urandom);
   endfunction

   function automatic logic [CODE_W-1:0] pick_code(input logic [ID_W-1:0] id);
      if (id == tracked_id && $urandom_range(0, 99) < 70)
         return CODE_64_BYTES;
      return CODE_W'($urandom);
   endfunction

   // mostly in order, sometimes a small skip, now and then anything
   function automatic logic [SEQ_W-1:0] pick_sequence();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return next_seq;
      if (roll < 85)
         return next_seq + SEQ_W'($urandom_range(1, 4));
      return SEQ_W'($urandom);
   endfunction

   // eight beats in order, one header throughout
   task automatic send_clean_frame();
      logic [ID_W-1:0]   id;
      logic              ext;
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] word;
      int                b;
      id   = pick_identifier();
      ext  = 1'($urandom);
      code = pick_code(id);
      for (b = 0; b < SLOT_BEATS; b++) begin
         word = {$urandom, $urandom};
         if (b == 0)
            word[SEQ_W-1:0] = pick_sequence();
         send_request(push_item(BEAT_W'(b), id, ext, code, word));
      end
   endtask

   // shuffled beats, missing beats, or a header that changes beat by beat
   task automatic send_broken_frame();
      int                order [SLOT_BEATS];
      int                b;
      int                j;
      int                t;
      int                style;
      logic [ID_W-1:0]   id;
      logic              ext;
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] word;
      style = $urandom_range(0, 2);
      id    = pick_identifier();
      ext   = 1'($urandom);
      code  = pick_code(id);
      for (b = 0; b < SLOT_BEATS; b++)
         order[b] = b;
      if (style == 0)
         for (b = SLOT_BEATS - 1; b > 0; b--) begin
            j = $urandom_range(0, b);
            t = order[b];
            order[b] = order[j];
            order[j] = t;
         end
      for (b = 0; b < SLOT_BEATS; b++) begin
         if (style == 2 || $urandom_range(0, 3) == 0) begin
            id   = pick_identifier();
            ext  = 1'($urandom);
            code = pick_code(id);
         end
         word = {$urandom, $urandom};
         if (order[b] == 0)
            word[SEQ_W-1:0] = pick_sequence();
         // a beat may go missing only where the slot already holds data for it
         if (!(style == 1 && order[b] != SLOT_BEATS - 1 && $urandom_range(0, 2) == 0 &&
               beat_written[tail_slot * SLOT_BEATS + order[b]]))
            send_request(push_item(BEAT_W'(order[b]), id, ext, code, word));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // pop straight out of reset, all unused fields at their top values
   task automatic test_empty_pop();
      req_item_type it;
      it = push_item('1, '1, 1'b1, '1, '1);
      it.operation = OP_POP;
      send_request(it);
   endtask

   // Sequence tracking at the reset identifier and header capture on the
   // closing beat, then both frames popped and one pop too many.
   task automatic test_sequence_and_header();
      int b;
      // first tracked frame only primes the expected number (0xff, so it wraps)
      send_request(push_item(FIRST_BEAT, TRACKED_RESET, 1'b1, CODE_64_BYTES,
                             {56'h0, 8'hff}));
      send_request(push_item(3'd1, TRACKED_RESET, 1'b1, CODE_64_BYTES, '1));
      send_request(push_item(3'd2, TRACKED_RESET, 1'b1, CODE_64_BYTES,
                             64'haaaa_aaaa_aaaa_aaaa));
      send_request(push_item(3'd3, TRACKED_RESET, 1'b1, CODE_64_BYTES,
                             64'h5555_5555_5555_5555));
      send_request(push_item(3'd4, TRACKED_RESET, 1'b1, CODE_64_BYTES, '0));
      for (b = 5; b < SLOT_BEATS; b++)
         send_request(push_item(BEAT_W'(b), TRACKED_RESET, 1'b1, CODE_64_BYTES,
                                {$urandom, $urandom}));
      // in order after the wrap: no gap
      send_request(push_item(FIRST_BEAT, TRACKED_RESET, 1'b0, CODE_64_BYTES,
                             {56'hff_ffff_ffff_ffff, 8'h00}));
      // not a 64-byte code: ignored
      send_request(push_item(FIRST_BEAT, TRACKED_RESET, 1'b0, 4'd14, {56'h0, 8'h80}));
      // repeated number: modulo gap of 255, extended flag makes no odds
      send_request(push_item(FIRST_BEAT, TRACKED_RESET, 1'b1, CODE_64_BYTES,
                             {56'h0, 8'h00}));
      // header differs beat by beat; only the closing one is kept
      send_request(push_item(FIRST_BEAT, TRACKED_RESET ^ 29'h1, 1'b1, CODE_64_BYTES,
                             {$urandom, $urandom}));
      for (b = 1; b < SLOT_BEATS - 1; b++)
         send_request(push_item(BEAT_W'(b), ID_W'($urandom), 1'($urandom),
                                CODE_W'($urandom), {$urandom, $urandom}));
      send_request(push_item(LAST_BEAT, '1, 1'b0, 4'd0, {$urandom, $urandom}));
      send_request(pop_item());
      send_request(pop_item());
      send_request(pop_item());
      wait_drained();
   endtask

   // Receiver holds off while frames keep coming, so the output register and
   // then the input stall; the queue is then filled, overflowed and emptied.
   task automatic test_fill_and_drop();
      rsp_pauses = 1'b1;
      @(posedge clock);
      hold_offs_asked++;
      @(negedge clock);
      while (queue_fill() < DEPTH - 1)
         send_clean_frame();
      send_clean_frame();                                 // dropped, queue full
      send_request(push_item(LAST_BEAT, tracked_id, 1'($urandom), CODE_W'($urandom),
                             {$urandom, $urandom}));      // lone closing beat, dropped
      while (queue_fill() > 0)
         send_request(pop_item());
      send_request(pop_item());
      wait_drained();
   endtask

   // Mixed traffic: mostly whole frames with random content, some broken
   // frames, pops, and odd single items.
   task automatic test_random_traffic(input int item_budget);
      req_item_type it;
      int           first;
      int           roll;
      int           n;
      first = items_sent;
      while (items_sent - first < item_budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            send_clean_frame();
         end else if (roll < 70) begin
            send_broken_frame();
         end else if (roll < 92) begin
            n = $urandom_range(1, 3);
            repeat (n) send_request(pop_item());
         end else begin
            it = pop_item();
            it.operation = op_type'($urandom_range(0, 1));
            send_request(it);
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      clear_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pop();
      test_sequence_and_header();
      write_tracked('1);
      test_fill_and_drop();

      write_tracked('0);
      req_pauses = 1'b1;
      test_random_traffic(10);

      write_tracked(ID_W'($urandom));
      rsp_pauses = 1'b0;
      test_random_traffic(10);

      write_tracked(TRACKED_RESET);
      rsp_pauses = 1'b1;
      test_random_traffic(10);

      $display("Covered %0d req items and %0d rsp items over %0d tracked-id settings,",
               items_sent, results_checked, settings_used);
      $display("with %0d frames closed, %0d dropped while full, %0d sequence numbers skipped.",
               frames_seen_cnt, frames_dropped_cnt, gap_total);
      if (mismatch_count == 0)
         $display("can_frame_receive_queue verification clean");
      else
         $display("can_frame_receive_queue verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("can_frame_receive_queue verification failed");
      $finish;
   end

endmodule
